>>> src/sfr_pkg.sv
// Types and constants shared by the session frame receiver.
package sfr_pkg;

	typedef enum logic [2:0] {
		REQ_RX_BYTE   = 3'd0,
		REQ_TICK      = 3'd1,
		REQ_LOGIN     = 3'd2,
		REQ_LOGOUT    = 3'd3,
		REQ_DATA_SENT = 3'd4
	} req_kind_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_PAYLOAD  = 3'd1,
		EV_SESSION  = 3'd2,
		EV_ACCEPTED = 3'd3,
		EV_REJECTED = 3'd4,
		EV_END      = 3'd5,
		EV_PROTOCOL = 3'd6,
		EV_TIMEOUT  = 3'd7
	} event_kind_t;

	typedef enum logic [1:0] {
		LINK_DOWN   = 2'd0,
		LINK_LOGIN  = 2'd1,
		LINK_ACTIVE = 2'd2
	} link_state_t;

	typedef enum logic [1:0] {
		PH_LEN_HI = 2'd0,
		PH_LEN_LO = 2'd1,
		PH_TYPE   = 2'd2,
		PH_BODY   = 2'd3
	} parse_phase_t;

	typedef enum logic [1:0] {
		DIG_SKIP = 2'd0,
		DIG_IN   = 2'd1,
		DIG_STOP = 2'd2
	} digit_phase_t;

	// Register index codes (paddr bit 2)
	localparam logic REG_HEARTBEAT  = 1'b0;
	localparam logic REG_RX_TIMEOUT = 1'b1;

	localparam logic [15:0] HEARTBEAT_RESET  = 16'd1000;
	localparam logic [15:0] RX_TIMEOUT_RESET = 16'd15000;

	// Frame type letters
	localparam logic [7:0] TYPE_ACCEPTED = 8'h41; // 'A'
	localparam logic [7:0] TYPE_REJECTED = 8'h4A; // 'J'
	localparam logic [7:0] TYPE_HEARTBT  = 8'h48; // 'H'
	localparam logic [7:0] TYPE_END      = 8'h5A; // 'Z'
	localparam logic [7:0] TYPE_SEQUENCE = 8'h53; // 'S'

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam int unsigned ACCEPT_LEN    = 31;
	localparam int unsigned REJECT_LEN    = 2;
	localparam int unsigned SESSION_LEN   = 10;
	localparam int unsigned SEQ_FIELD_LEN = 20;
	// Body bytes of an accept frame with more remaining than this are session bytes
	localparam logic [15:0] SESSION_SPLIT = 16'(ACCEPT_LEN - 1 - SESSION_LEN);

	localparam logic [62:0] SEQ_MAX = {63{1'b1}};

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [62:0] sequence_number;
		logic [1:0]  session_status;
		logic        send_heartbeat;
	} result_t;

endpackage

>>> src/session_frame_receiver.sv
// Top level of the session frame receiver: framing parser, session state and timers.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   sfr_pkg::item_t
//   result    out        result_valid/result_stall sfr_pkg::result_t
//   config    in         APB psel/penable/pready   heartbeat period, rx timeout
//
// One word in, one result word out, registered first in s1 and then in the output
// register. A new word can enter every cycle unless the result is stalled; the single
// state update per word (parser, sequence accumulator, timers) in s1 sets the rate.
// Reset is asynchronous, active low, and clears all session and parse state.
// A stalled result holds in the output register while one more word waits in s1.
module session_frame_receiver #(
	parameter int unsigned TIMER_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sfr_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output sfr_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import sfr_pkg::*;

	// Configuration registers
	logic [15:0] heartbeat_q;
	logic [15:0] rx_timeout_q;

	// Input stage
	logic  valid_s1;
	item_t item_s1;
	logic  out_free;
	logic  fire;

	// Session and parser state
	parse_phase_t     parse_q, parse_d;
	logic [15:0]      flen_q, flen_d;
	logic [7:0]       fkind_q, fkind_d;
	logic [15:0]      brem_q, brem_d;
	link_state_t      link_q, link_d;
	logic             halt_q, halt_d;
	logic [62:0]      expseq_q, expseq_d;
	logic [62:0]      acc_q, acc_d;
	digit_phase_t     dig_q, dig_d;
	logic [TIMER_WIDTH-1:0] tx_q, tx_d;
	logic [TIMER_WIDTH-1:0] rx_q, rx_d;

	// Per-word result terms
	event_kind_t evt;
	logic [7:0]  data;
	logic        last;
	logic        beat;

	// Helpers
	logic [66:0] acc_x10;
	logic [15:0] brem_dec;
	logic [15:0] flen_dec;
	logic [TIMER_WIDTH-1:0] tx_inc;
	logic [TIMER_WIDTH-1:0] rx_inc;
	logic        bad;
	logic        is_digit;

	result_t result_d;
	logic    result_valid_q;
	result_t result_q;

	// ---------------------------------------------------------------- config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heartbeat_q  <= HEARTBEAT_RESET;
			rx_timeout_q <= RX_TIMEOUT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_HEARTBEAT:  heartbeat_q  <= pwdata[15:0];
				REG_RX_TIMEOUT: rx_timeout_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HEARTBEAT:  prdata = {16'h0000, heartbeat_q};
			REG_RX_TIMEOUT: prdata = {16'h0000, rx_timeout_q};
			default:        prdata = 32'h0000_0000;
		endcase
	end

	// ---------------------------------------------------------------- handshake
	// Process the word in s1 whenever the output register is empty or draining.
	assign out_free   = !result_valid_q || !result_stall;
	assign fire       = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// ---------------------------------------------------------------- datapath helpers
	// Times ten plus the digit, by shift and add; overflow past 63 bits saturates.
	assign acc_x10  = ({4'b0000, acc_q} << 3) + ({4'b0000, acc_q} << 1)
	                + 67'(item_s1.rx_byte - CHAR_ZERO);
	assign brem_dec = brem_q - 16'd1;
	assign flen_dec = flen_q - 16'd1;
	assign tx_inc   = (&tx_q) ? tx_q : tx_q + TIMER_WIDTH'(1);
	assign rx_inc   = (&rx_q) ? rx_q : rx_q + TIMER_WIDTH'(1);
	assign is_digit = (item_s1.rx_byte >= CHAR_ZERO) && (item_s1.rx_byte <= CHAR_NINE);

	// ---------------------------------------------------------------- next state
	always_comb begin
		parse_d  = parse_q;
		flen_d   = flen_q;
		fkind_d  = fkind_q;
		brem_d   = brem_q;
		link_d   = link_q;
		halt_d   = halt_q;
		expseq_d = expseq_q;
		acc_d    = acc_q;
		dig_d    = dig_q;
		tx_d     = tx_q;
		rx_d     = rx_q;
		evt      = EV_NONE;
		data     = 8'h00;
		last     = 1'b0;
		beat     = 1'b0;
		bad      = 1'b0;

		unique case (item_s1.req_type)
			REQ_RX_BYTE: begin
				if (!halt_q) begin
					rx_d = '0;
					unique case (parse_q)
						PH_LEN_HI: begin
							flen_d  = {item_s1.rx_byte, 8'h00};
							parse_d = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							flen_d  = {flen_q[15:8], item_s1.rx_byte};
							parse_d = PH_TYPE;
						end
						PH_TYPE: begin
							fkind_d = item_s1.rx_byte;
							if (flen_q == 16'd0) begin
								bad = 1'b1;
							end else begin
								brem_d  = flen_dec;
								parse_d = (flen_dec != 16'd0) ? PH_BODY : PH_LEN_HI;
								unique case (item_s1.rx_byte)
									TYPE_ACCEPTED: begin
										if (flen_q != 16'(ACCEPT_LEN)) begin
											bad = 1'b1;
										end else begin
											link_d = LINK_ACTIVE;
											acc_d  = '0;
											dig_d  = DIG_SKIP;
										end
									end
									TYPE_REJECTED: bad = (flen_q != 16'(REJECT_LEN));
									TYPE_HEARTBT:  bad = (flen_q != 16'd1);
									TYPE_END: begin
										if (flen_q != 16'd1) begin
											bad = 1'b1;
										end else begin
											link_d = LINK_DOWN;
											evt    = EV_END;
										end
									end
									TYPE_SEQUENCE: bad = (flen_q < 16'd2);
									default: ;
								endcase
							end
						end
						PH_BODY: begin
							brem_d = brem_dec;
							if (brem_dec == 16'd0) begin
								parse_d = PH_LEN_HI;
							end
							unique case (fkind_q)
								TYPE_ACCEPTED: begin
									if (brem_q > SESSION_SPLIT) begin
										evt  = EV_SESSION;
										data = item_s1.rx_byte;
									end else if (dig_q == DIG_SKIP &&
									             item_s1.rx_byte == CHAR_SPACE) begin
										dig_d = dig_q;
									end else if (dig_q != DIG_STOP && is_digit) begin
										dig_d = DIG_IN;
										acc_d = (acc_x10 > 67'(SEQ_MAX)) ? SEQ_MAX
										                                 : acc_x10[62:0];
									end else begin
										dig_d = DIG_STOP;
									end
									if (brem_dec == 16'd0) begin
										expseq_d = acc_d;
										evt      = EV_ACCEPTED;
									end
								end
								TYPE_REJECTED: begin
									evt    = EV_REJECTED;
									data   = item_s1.rx_byte;
									link_d = LINK_DOWN;
								end
								TYPE_SEQUENCE: begin
									evt  = EV_PAYLOAD;
									data = item_s1.rx_byte;
									if (brem_dec == 16'd0) begin
										last = 1'b1;
										if (expseq_q != SEQ_MAX) begin
											expseq_d = expseq_q + 63'd1;
										end
									end
								end
								default: ;
							endcase
						end
						default: ;
					endcase
					// Drop the frame and halt on a bad length
					if (bad) begin
						parse_d = PH_LEN_HI;
						flen_d  = '0;
						fkind_d = '0;
						brem_d  = '0;
						dig_d   = DIG_SKIP;
						halt_d  = 1'b1;
						link_d  = LINK_DOWN;
						evt     = EV_PROTOCOL;
						data    = 8'h00;
					end
				end
			end
			REQ_TICK: begin
				tx_d = tx_inc;
				rx_d = rx_inc;
				if (link_q == LINK_LOGIN || link_q == LINK_ACTIVE) begin
					if (tx_inc >= TIMER_WIDTH'(heartbeat_q)) begin
						beat = 1'b1;
						tx_d = '0;
					end
					if (rx_inc >= TIMER_WIDTH'(rx_timeout_q)) begin
						evt     = EV_TIMEOUT;
						link_d  = LINK_DOWN;
						halt_d  = 1'b1;
						parse_d = PH_LEN_HI;
						flen_d  = '0;
						fkind_d = '0;
						brem_d  = '0;
						dig_d   = DIG_SKIP;
					end
				end
			end
			REQ_LOGIN: begin
				link_d  = LINK_LOGIN;
				tx_d    = '0;
				rx_d    = '0;
				halt_d  = 1'b0;
				parse_d = PH_LEN_HI;
				flen_d  = '0;
				fkind_d = '0;
				brem_d  = '0;
				dig_d   = DIG_SKIP;
			end
			REQ_LOGOUT:    link_d = LINK_DOWN;
			REQ_DATA_SENT: tx_d   = '0;
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- result word
	always_comb begin
		result_d.event_kind      = evt;
		result_d.data_byte       = data;
		result_d.last_byte       = last;
		result_d.sequence_number = expseq_d;
		result_d.session_status  = link_d;
		result_d.send_heartbeat  = beat;
	end

	// ---------------------------------------------------------------- state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q  <= PH_LEN_HI;
			flen_q   <= '0;
			fkind_q  <= '0;
			brem_q   <= '0;
			link_q   <= LINK_DOWN;
			halt_q   <= 1'b0;
			expseq_q <= '0;
			acc_q    <= '0;
			dig_q    <= DIG_SKIP;
			tx_q     <= '0;
			rx_q     <= '0;
		end else if (fire) begin
			parse_q  <= parse_d;
			flen_q   <= flen_d;
			fkind_q  <= fkind_d;
			brem_q   <= brem_d;
			link_q   <= link_d;
			halt_q   <= halt_d;
			expseq_q <= expseq_d;
			acc_q    <= acc_d;
			dig_q    <= dig_d;
			tx_q     <= tx_d;
			rx_q     <= rx_d;
		end
	end

	// Output register: load on fire, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---------------------------------------------------------------- assertions
	a_halt_down: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |-> link_q == LINK_DOWN)
		else $error("receiver halted while session not down");

	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		parse_q == PH_BODY |-> brem_q != 16'd0)
		else $error("body phase with nothing remaining");

	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_byte |-> result.event_kind == EV_PAYLOAD)
		else $error("last mark on a non-payload word");

	a_rose_after_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a word in s1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(item_s1))
		else $error("waiting word in s1 lost or changed");

endmodule

>>> verif/session_frame_receiver_tb.sv
`timescale 1ns / 1ps
// Testbench for the session frame receiver: framed byte streams, ticks and session events.
module session_frame_receiver_tb;
	import sfr_pkg::*;

	localparam int TIMER_W = 32;
	localparam logic [TIMER_W-1:0] TIMER_TOP = '1;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// Request codes the block must ignore
	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	// A frame type with no meaning to the block: its body is skipped
	localparam logic [7:0] TYPE_OTHER = 8'h58;

	// Ways to fill the 20-byte sequence field of a login-accepted frame
	typedef enum int {
		FIELD_VALUE,
		FIELD_NINES,
		FIELD_BLANK,
		FIELD_MIXED
	} field_style_t;

	// Mirrors the session state, keeps the results still owed and checks each one.
	class session_tracker;
		logic [15:0]        beat_period;
		logic [15:0]        silence_limit;
		parse_phase_t       phase;
		logic [15:0]        frame_len;
		logic [15:0]        body_left;
		logic [7:0]         frame_type;
		link_state_t        link;
		bit                 halted;
		logic [62:0]        next_seq;
		logic [62:0]        seq_acc;
		digit_phase_t       digits;
		logic [TIMER_W-1:0] tx_quiet;
		logic [TIMER_W-1:0] rx_quiet;
		result_t            awaited[$];
		int                 mismatches;

		function new();
			beat_period = HEARTBEAT_RESET;
			silence_limit = RX_TIMEOUT_RESET;
			clear_framing();
			link = LINK_DOWN;
			halted = 1'b0;
			next_seq = '0;
			seq_acc = '0;
			tx_quiet = '0;
			rx_quiet = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic idx, logic [15:0] val);
			if (idx == REG_HEARTBEAT)
				beat_period = val;
			else
				silence_limit = val;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void clear_framing();
			phase = PH_LEN_HI;
			frame_len = '0;
			frame_type = '0;
			body_left = '0;
			digits = DIG_SKIP;
		endfunction

		// Fold one character of the sequence field into the accumulator, saturating.
		function void take_digit(logic [7:0] b);
			logic [63:0] d;
			logic [63:0] room;
			if (digits == DIG_SKIP && b == CHAR_SPACE)
				return;
			if (digits != DIG_STOP && b >= CHAR_ZERO && b <= CHAR_NINE) begin
				d = 64'(b - CHAR_ZERO);
				digits = DIG_IN;
				room = ({1'b0, SEQ_MAX} - d) / 10;
				if ({1'b0, seq_acc} > room)
					seq_acc = SEQ_MAX;
				else
					seq_acc = 63'({1'b0, seq_acc} * 10 + d);
			end else begin
				digits = DIG_STOP;
			end
		endfunction

		// Advance the frame parser by one received byte.
		function void take_byte(logic [7:0] b, inout result_t r);
			bit          bad;
			logic [15:0] was_left;
			logic [15:0] pos;
			bad = 1'b0;
			case (phase)
			PH_LEN_HI: begin
				frame_len = {b, 8'h00};
				phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				frame_len[7:0] = b;
				phase = PH_TYPE;
			end
			PH_TYPE: begin
				frame_type = b;
				if (frame_len == 0) begin
					bad = 1'b1;
				end else begin
					body_left = frame_len - 16'd1;
					if (body_left != 0)
						phase = PH_BODY;
					else
						phase = PH_LEN_HI;
					case (b)
					TYPE_ACCEPTED: begin
						if (frame_len != ACCEPT_LEN) begin
							bad = 1'b1;
						end else begin
							link = LINK_ACTIVE;
							seq_acc = '0;
							digits = DIG_SKIP;
						end
					end
					TYPE_REJECTED: if (frame_len != REJECT_LEN) bad = 1'b1;
					TYPE_HEARTBT: if (frame_len != 1) bad = 1'b1;
					TYPE_END: begin
						if (frame_len != 1) begin
							bad = 1'b1;
						end else begin
							link = LINK_DOWN;
							r.event_kind = EV_END;
						end
					end
					TYPE_SEQUENCE: if (frame_len < 2) bad = 1'b1;
					default: ;
					endcase
				end
			end
			default: begin
				was_left = body_left;
				body_left = was_left - 16'd1;
				if (body_left == 0)
					phase = PH_LEN_HI;
				case (frame_type)
				TYPE_ACCEPTED: begin
					pos = 16'(ACCEPT_LEN - 1) - was_left;
					if (pos < SESSION_LEN) begin
						r.event_kind = EV_SESSION;
						r.data_byte = b;
					end else begin
						take_digit(b);
					end
					if (body_left == 0) begin
						next_seq = seq_acc;
						r.event_kind = EV_ACCEPTED;
					end
				end
				TYPE_REJECTED: begin
					r.event_kind = EV_REJECTED;
					r.data_byte = b;
					link = LINK_DOWN;
				end
				TYPE_SEQUENCE: begin
					r.event_kind = EV_PAYLOAD;
					r.data_byte = b;
					if (body_left == 0) begin
						r.last_byte = 1'b1;
						if (next_seq != SEQ_MAX)
							next_seq = next_seq + 63'd1;
					end
				end
				default: ;
				endcase
			end
			endcase
			if (bad) begin
				clear_framing();
				halted = 1'b1;
				link = LINK_DOWN;
				r.event_kind = EV_PROTOCOL;
			end
		endfunction

		// Predict the result of one accepted input word and queue it.
		function void note_word(item_t w);
			result_t r;
			r = '0;
			case (w.req_type)
			REQ_RX_BYTE: begin
				if (!halted) begin
					rx_quiet = '0;
					take_byte(w.rx_byte, r);
				end
			end
			REQ_TICK: begin
				if (tx_quiet != TIMER_TOP)
					tx_quiet = tx_quiet + 1'b1;
				if (rx_quiet != TIMER_TOP)
					rx_quiet = rx_quiet + 1'b1;
				if (link == LINK_LOGIN || link == LINK_ACTIVE) begin
					if (tx_quiet >= beat_period) begin
						r.send_heartbeat = 1'b1;
						tx_quiet = '0;
					end
					if (rx_quiet >= silence_limit) begin
						r.event_kind = EV_TIMEOUT;
						link = LINK_DOWN;
						halted = 1'b1;
						clear_framing();
					end
				end
			end
			REQ_LOGIN: begin
				link = LINK_LOGIN;
				tx_quiet = '0;
				rx_quiet = '0;
				halted = 1'b0;
				clear_framing();
			end
			REQ_LOGOUT: link = LINK_DOWN;
			REQ_DATA_SENT: tx_quiet = '0;
			default: ;
			endcase
			r.sequence_number = next_seq;
			r.session_status = link;
			awaited.push_back(r);
		endfunction

		// Compare one accepted result word with the oldest prediction.
		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word with nothing predicted: ev=%0d data=%02h seq=%0d",
						got.event_kind, got.data_byte, got.sequence_number);
				return;
			end
			want = awaited.pop_front();
			if (got.event_kind !== want.event_kind || got.data_byte !== want.data_byte ||
				got.last_byte !== want.last_byte ||
				got.sequence_number !== want.sequence_number ||
				got.session_status !== want.session_status ||
				got.send_heartbeat !== want.send_heartbeat) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch expected: ev=%0d data=%02h last=%0b seq=%0d st=%0d hb=%0b",
						want.event_kind, want.data_byte, want.last_byte,
						want.sequence_number, want.session_status, want.send_heartbeat);
					$display("         actual:   ev=%0d data=%02h last=%0b seq=%0d st=%0d hb=%0b",
						got.event_kind, got.data_byte, got.last_byte,
						got.sequence_number, got.session_status, got.send_heartbeat);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	session_tracker tracker;

	// Stimulus knobs shared by the driving tasks
	bit          idle_on = 1'b1;  // random gaps on both channels
	bit          mix_in = 1'b0;   // scatter ticks and other requests between stream bytes
	bit          squeeze = 1'b0;  // ask the receiver for one long hold-off
	int          tick_span = 8;
	int          words_sent = 0;
	int unsigned cycles = 0;

	session_frame_receiver #(.TIMER_WIDTH(TIMER_W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Abort a hung run; the limit is far above the slowest correct run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Sample both handshakes at the edge, before anything driven at it lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				tracker.note_word(item);
			if (result_valid && !result_stall)
				tracker.check_result(result);
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request so the
	// block backs up and stalls its input while the sender keeps offering words.
	initial begin
		forever begin
			if (squeeze) begin
				result_stall <= 1'b1;
				repeat (300) @(posedge clk);
				squeeze = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Offer one word, maybe after an idle burst, and hold it until accepted.
	task automatic send_word(logic [2:0] kind, logic [7:0] b);
		item_t w;
		w.req_type = kind;
		w.rx_byte = b;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		words_sent++;
	endtask

	// Drop a non-byte request into the stream: mostly ticks, rarely a session change.
	task automatic send_side_req();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			send_word(REQ_TICK, 8'($urandom));
		else if (pick < 85)
			send_word(REQ_DATA_SENT, 8'($urandom));
		else if (pick < 95)
			send_word(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), 8'($urandom));
		else if (pick < 98)
			send_word(REQ_LOGOUT, 8'($urandom));
		else
			send_word(REQ_LOGIN, 8'($urandom));
	endtask

	task automatic send_rx(logic [7:0] b);
		if (mix_in && $urandom_range(0, 19) == 0)
			send_side_req();
		send_word(REQ_RX_BYTE, b);
	endtask

	task automatic send_len(logic [15:0] len);
		send_rx(len[15:8]);
		send_rx(len[7:0]);
	endtask

	// Length, type and (len - 1) random body bytes.
	task automatic send_frame(logic [7:0] kind, logic [15:0] len);
		send_len(len);
		send_rx(kind);
		for (int i = 1; i < len; i++)
			send_rx(8'($urandom));
	endtask

	// Login-accepted frame: 10 session bytes and a 20-byte sequence field.
	task automatic send_accept(field_style_t style, logic [63:0] val);
		logic [7:0] field [SEQ_FIELD_LEN];
		string      digits_txt;
		int         pad;
		int         nsp;
		int         ndig;
		send_len(16'(ACCEPT_LEN));
		send_rx(TYPE_ACCEPTED);
		for (int i = 0; i < SESSION_LEN; i++)
			send_rx(8'($urandom));
		digits_txt = $sformatf("%0d", val);
		pad = SEQ_FIELD_LEN - digits_txt.len();
		nsp = $urandom_range(0, SEQ_FIELD_LEN);
		ndig = $urandom_range(0, SEQ_FIELD_LEN - nsp);
		for (int i = 0; i < SEQ_FIELD_LEN; i++) begin
			case (style)
			FIELD_VALUE: field[i] = (i < pad) ? CHAR_SPACE : digits_txt[i - pad];
			FIELD_NINES: field[i] = CHAR_NINE;
			FIELD_BLANK: field[i] = CHAR_SPACE;
			default: begin
				// spaces, digits, then anything at all
				if (i < nsp)
					field[i] = CHAR_SPACE;
				else if (i < nsp + ndig)
					field[i] = CHAR_ZERO + 8'($urandom_range(0, 9));
				else
					field[i] = 8'($urandom);
			end
			endcase
		end
		for (int i = 0; i < SEQ_FIELD_LEN; i++)
			send_rx(field[i]);
	endtask

	// Length, type and up to three random bytes; the block should halt at the type byte.
	task automatic send_bad(logic [7:0] kind, logic [15:0] len);
		send_len(len);
		send_rx(kind);
		repeat ($urandom_range(0, 3)) send_rx(8'($urandom));
	endtask

	task automatic send_bad_frame();
		logic [15:0] len;
		logic [7:0]  kind;
		case ($urandom_range(0, 5))
		0: begin
			kind = 8'($urandom);
			len = 16'd0;
		end
		1: begin
			kind = TYPE_ACCEPTED;
			do len = 16'($urandom); while (len == ACCEPT_LEN);
		end
		2: begin
			kind = TYPE_REJECTED;
			do len = 16'($urandom); while (len == REJECT_LEN);
		end
		3: begin
			kind = TYPE_HEARTBT;
			do len = 16'($urandom); while (len == 1);
		end
		4: begin
			kind = TYPE_END;
			do len = 16'($urandom); while (len == 1);
		end
		default: begin
			kind = TYPE_SEQUENCE;
			len = 16'($urandom_range(0, 1));
		end
		endcase
		send_bad(kind, len);
	endtask

	task automatic tick_burst(int span);
		repeat ($urandom_range(1, span)) send_word(REQ_TICK, 8'($urandom));
	endtask

	function automatic logic [63:0] random_seq();
		return {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
	endfunction

	// One login followed by a handful of frames and requests of random kinds.
	task automatic random_session();
		int pick;
		send_word(REQ_LOGIN, 8'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 85)
			send_accept(field_style_t'($urandom_range(FIELD_VALUE, FIELD_MIXED)), random_seq());
		else if (pick < 92)
			send_frame(TYPE_REJECTED, 16'(REJECT_LEN));
		repeat ($urandom_range(1, 8)) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_frame(TYPE_SEQUENCE, ($urandom_range(0, 40) == 0) ?
					16'($urandom_range(2, 300)) : 16'($urandom_range(2, 12)));
			else if (pick < 55)
				send_frame(TYPE_HEARTBT, 16'd1);
			else if (pick < 67)
				tick_burst(tick_span);
			else if (pick < 74)
				send_word(REQ_DATA_SENT, 8'($urandom));
			else if (pick < 79)
				send_frame(8'($urandom), 16'($urandom_range(1, 6)));
			else if (pick < 82)
				send_accept(field_style_t'($urandom_range(FIELD_VALUE, FIELD_MIXED)),
					random_seq());
			else if (pick < 85)
				send_frame(TYPE_END, 16'd1);
			else if (pick < 88)
				send_bad_frame();
			else if (pick < 91)
				repeat ($urandom_range(1, 5)) send_rx(8'($urandom));
			else if (pick < 93)
				send_word(REQ_LOGOUT, 8'($urandom));
			else if (pick < 96)
				send_word(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), 8'($urandom));
			else
				tick_burst(2 * tick_span);
		end
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(logic idx, logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_reg(idx, val);
	endtask

	// Wait until every predicted word has come back.
	task automatic settle();
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic directed_checks();
		// no session: ignored codes, data sent, logout and ticks give nothing
		send_word(REQ_SPARE_LO, 8'h00);
		send_word(REQ_SPARE_HI, 8'hFF);
		send_word(REQ_DATA_SENT, 8'h5A);
		send_word(REQ_LOGOUT, 8'hA5);
		tick_burst(3);
		// frames still parse with the link down
		send_frame(TYPE_HEARTBT, 16'd1);
		// sequence one below the top, then step it to the top and hold it there
		send_word(REQ_LOGIN, 8'h00);
		send_accept(FIELD_VALUE, 64'h7FFF_FFFF_FFFF_FFFE);
		send_frame(TYPE_SEQUENCE, 16'd2);
		send_frame(TYPE_SEQUENCE, 16'd5);
		// twenty digits overflow, nines saturate, spaces alone load zero
		send_accept(FIELD_VALUE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_accept(FIELD_NINES, 64'd0);
		send_accept(FIELD_BLANK, 64'd0);
		send_accept(FIELD_MIXED, 64'd0);
		send_frame(TYPE_OTHER, 16'd4);
		// heartbeat request, data sent clears it, then silence times out
		tick_burst(1);
		send_word(REQ_TICK, 8'h00);
		send_word(REQ_DATA_SENT, 8'h00);
		repeat (6) send_word(REQ_TICK, 8'h00);
		repeat (3) send_rx(8'hFF);
		send_word(REQ_LOGIN, 8'h00);
		send_frame(TYPE_END, 16'd1);
		send_word(REQ_LOGIN, 8'h00);
		send_frame(TYPE_REJECTED, 16'(REJECT_LEN));
		// lengths that do not fit their type
		send_word(REQ_LOGIN, 8'h00);
		send_bad(TYPE_HEARTBT, 16'd0);
		send_word(REQ_LOGIN, 8'h00);
		send_bad(TYPE_ACCEPTED, 16'd30);
		send_word(REQ_LOGIN, 8'h00);
		send_bad(TYPE_SEQUENCE, 16'd1);
		send_word(REQ_LOGIN, 8'h00);
		send_bad(TYPE_HEARTBT, 16'd2);
		send_word(REQ_LOGIN, 8'h00);
		send_bad(TYPE_END, 16'hFFFF);
		send_word(REQ_LOGIN, 8'h00);
		send_bad(TYPE_REJECTED, 16'd3);
		// logout in the middle of a payload frame: the frame keeps streaming
		send_word(REQ_LOGIN, 8'h00);
		send_accept(FIELD_VALUE, 64'd41);
		send_len(16'd4);
		send_rx(TYPE_SEQUENCE);
		send_rx(8'h00);
		send_word(REQ_LOGOUT, 8'h00);
		send_rx(8'hFF);
		send_rx(8'h80);
		item_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [15:0] beat, logic [15:0] silence, int span, int goal,
		bit press);
		int stop_at;
		settle();
		write_reg(REG_HEARTBEAT, beat);
		write_reg(REG_RX_TIMEOUT, silence);
		tick_span = span;
		mix_in = 1'b1;
		if (press)
			squeeze = 1'b1;
		stop_at = words_sent + goal;
		while (words_sent < stop_at)
			random_session();
		item_valid <= 1'b0;
	endtask

	initial begin
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short periods so heartbeats and timeouts show up in the directed part
		write_reg(REG_HEARTBEAT, 16'd2);
		write_reg(REG_RX_TIMEOUT, 16'd6);
		directed_checks();

		run_phase(HEARTBEAT_RESET, RX_TIMEOUT_RESET, 30, 250, 1'b0);
		run_phase(16'd3, 16'd20, 30, 280, 1'b1);
		run_phase(16'hFFFF, 16'hFFFF, 20, 200, 1'b0);
		run_phase(16'd1, 16'd1, 4, 120, 1'b0);
		// zero registers: every tick in a session fires both checks
		run_phase(16'd0, 16'd0, 3, 60, 1'b0);
		settle();
		idle_on = 1'b0;
		run_phase(16'd5, 16'd40, 50, 250, 1'b0);

		settle();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
